@@ hw/rtl/rwt_pkg.sv @@
package rwt_pkg;

    localparam int VALUE_W = 32;
    localparam int RANK_W  = 7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_LATCH,
        ST_SWEEP,
        ST_EMIT
    } rwt_state_t;

endpackage

@@ hw/rtl/rwt_ram.sv @@
module rwt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hw/rtl/rank_with_ties.sv @@
// channel   direction  handshake                     payload
// load      in         start & !busy                 sample_value, final_element
// result    out        result_valid (one cycle)      rank_value, final_rank, overflow
// config    in         cfg_valid & cfg_ready         cfg_descending
//
// Loading accepts one item per cycle; busy stays low until the final item.
// Ranking then runs on the single comparator and value memory read port (n =
// elements stored): per result it latches one element, sweeps all n, then emits.
// rst_n clears count, overflow flag, setting and sequencer; the memory is not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
module rank_with_ties
    import rwt_pkg::*;
#(
    parameter int MAX_ELEMENTS = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [VALUE_W-1:0] sample_value,
    input  logic                      final_element,
    output logic                      result_valid,
    output logic [RANK_W-1:0]         rank_value,
    output logic                      final_rank,
    output logic                      overflow,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic                      cfg_descending
);

    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam int CW = $clog2(MAX_ELEMENTS + 1);

    rwt_state_t state_reg, state_next;

    logic [CW-1:0]      count_reg, count_next;
    logic               ovf_reg, ovf_next;
    logic               desc_reg;
    logic [AW-1:0]      k_reg, k_next;
    logic [CW-1:0]      m_reg, m_next;
    logic [VALUE_W-1:0] a_reg, a_next;
    logic [RANK_W-1:0]  rank_reg, rank_next;

    logic               accept;
    logic               room;
    logic               last_k;
    logic               sweep_done;
    logic               hit;
    logic               ram_we;
    logic [AW-1:0]      ram_raddr;
    logic [VALUE_W-1:0] ram_rdata;
    logic [VALUE_W-1:0] cmp_lhs;
    logic [VALUE_W-1:0] cmp_rhs;

    assign busy       = (state_reg != ST_IDLE);
    assign accept     = start && !busy;
    assign room       = (count_reg < CW'(MAX_ELEMENTS));
    assign ram_we     = accept && room;
    assign cfg_ready  = 1'b1;
    assign last_k     = ((CW'(k_reg) + CW'(1)) == count_reg);
    assign sweep_done = (m_reg == count_reg);

    // shared comparator: swap operands for descending order
    assign cmp_lhs = desc_reg ? a_reg : ram_rdata;
    assign cmp_rhs = desc_reg ? ram_rdata : a_reg;
    assign hit     = ($signed(cmp_lhs) < $signed(cmp_rhs));

    assign result_valid = (state_reg == ST_EMIT);
    assign rank_value   = rank_reg;
    assign final_rank   = result_valid && last_k;
    assign overflow     = ovf_reg;

    rwt_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_ELEMENTS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (sample_value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && final_element)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_LATCH;
            end
            ST_LATCH:
            begin
                state_next = ST_SWEEP;
            end
            ST_SWEEP:
            begin
                if (sweep_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                state_next = last_k ? ST_IDLE : ST_LATCH;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        k_next     = k_reg;
        m_next     = m_reg;
        a_next     = a_reg;
        rank_next  = rank_reg;
        ram_raddr  = k_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                k_next = '0;
                if (accept)
                begin
                    if (room)
                    begin
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
            end
            ST_FETCH:
            begin
                ram_raddr = k_reg;
            end
            ST_LATCH:
            begin
                // hold the element under test, issue the first sweep read
                a_next    = ram_rdata;
                ram_raddr = '0;
                m_next    = CW'(1);
                rank_next = RANK_W'(1);
            end
            ST_SWEEP:
            begin
                ram_raddr = m_reg[AW-1:0];
                if (hit)
                begin
                    rank_next = rank_reg + RANK_W'(1);
                end
                if (!sweep_done)
                begin
                    m_next = m_reg + CW'(1);
                end
            end
            ST_EMIT:
            begin
                if (last_k)
                begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                end
                else
                begin
                    // advance and prefetch the next element
                    k_next    = k_reg + AW'(1);
                    ram_raddr = k_reg + AW'(1);
                end
            end
            default:
            begin
                ram_raddr = k_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            desc_reg  <= 1'b0;
            k_reg     <= '0;
            m_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            k_reg     <= k_next;
            m_reg     <= m_next;
            if (cfg_valid && cfg_ready)
            begin
                desc_reg <= cfg_descending;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        rank_reg <= rank_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (rank_value != '0) && (rank_value <= RANK_W'(count_reg)))
        else $error("rank outside 1..n");

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && final_element) |=> busy && (count_reg != '0))
        else $error("final item did not start ranking");

    assert property (@(posedge clk) disable iff (!rst_n)
        final_rank |=> !busy && (count_reg == '0) && !overflow)
        else $error("vector not cleared after last rank");

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_ELEMENTS))
        else $error("element count beyond capacity");

endmodule
